### rtl/core/vdi_pkg.sv
`timescale 1ns / 1ps

package vdi_pkg;

	// key table geometry
	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// stream payload layout
	localparam int FIELD_W      = 32;
	localparam int KEY_FIELDS   = 8;
	localparam int KEY_W        = FIELD_W * KEY_FIELDS;
	localparam int OUT_INDEX_W  = 10;
	localparam int OUT_TDATA_W  = ((OUT_INDEX_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W  = 2;

	// m_tuser bit positions
	localparam int TUSER_IS_NEW     = 0;
	localparam int TUSER_TABLE_FULL = 1;

	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [KEY_W-1:0]       key_t;
	typedef logic [OUT_INDEX_W-1:0] out_index_t;

	localparam cnt_t CNT_FULL = cnt_t'(TABLE_DEPTH);
	localparam cnt_t CNT_ONE  = cnt_t'(1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

endpackage

### rtl/core/vdi_ram.sv
`timescale 1ns / 1ps

// simple dual-port RAM, one write and one registered read port
module vdi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### rtl/core/vertex_dedup_indexer.sv
`timescale 1ns / 1ps

// Vertex deduplicating indexer.
// Slave stream: one request per vertex. s_tdata carries the eight raw 32-bit
// attribute patterns, s_tuser the first-of-mesh flag that empties the table
// before the vertex is looked up.
// Master stream: one result per request. m_tdata carries the vertex index,
// m_tuser the is_new and table_full flags.
// A request is looked up by reading the key RAM one entry per cycle, from
// entry 0 up, comparing all 256 key bits against the held key. A hit stops
// the scan; a miss appends the key at the next free entry, or on a full
// table returns index zero with table_full set. One request is handled at
// a time; the next request is taken the cycle after the result is
// registered.
// The result sits in an output register, so the next request is taken while
// the previous result waits on m_tready. A stalled receiver holds the
// finishing request until the output register frees up.
// Reset empties the table (entry count to zero) and drops any result; the
// RAM contents are not cleared, entries at or above the count are never read.
module vertex_dedup_indexer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z (32 bits each)
	input  logic [vdi_pkg::KEY_W-1:0]        s_tdata,
	// first_of_mesh
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_index, then zero fill
	output logic [vdi_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// is_new, table_full
	output logic [vdi_pkg::OUT_TUSER_W-1:0]  m_tuser
);

	vdi_pkg::state_t     state_q;
	vdi_pkg::key_t       key_q;
	vdi_pkg::cnt_t       cnt_q;
	vdi_pkg::cnt_t       issue_q;
	vdi_pkg::cnt_t       issue_nxt;
	logic                hit_q;
	vdi_pkg::idx_t       hit_idx_q;

	// compare stage, lines up with the RAM read data
	logic                cmp_valid_s1;
	logic                cmp_last_s1;
	vdi_pkg::idx_t       cmp_idx_s1;

	// output register
	logic                   out_valid_q;
	vdi_pkg::out_index_t    out_index_q;
	logic                   out_new_q;
	logic                   out_full_q;

	logic                accept;
	logic                rd_en;
	vdi_pkg::key_t       rd_data;
	logic                match;
	logic                scan_done;
	logic                out_free;
	logic                tbl_full;
	logic                wr_en;

	assign s_tready  = (state_q == vdi_pkg::ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign issue_nxt = issue_q + vdi_pkg::CNT_ONE;

	// a hit or the last compare without a hit ends the scan
	assign match     = cmp_valid_s1 && (rd_data == key_q);
	assign scan_done = match || (cmp_valid_s1 && cmp_last_s1);
	assign rd_en     = (state_q == vdi_pkg::ST_SCAN) && (issue_q < cnt_q) && !scan_done;

	assign out_free  = !out_valid_q || m_tready;
	assign tbl_full  = (cnt_q == vdi_pkg::CNT_FULL);
	assign wr_en     = (state_q == vdi_pkg::ST_FINISH) && out_free && !hit_q && !tbl_full;

	vdi_ram #(
		.WIDTH (vdi_pkg::KEY_W),
		.DEPTH (vdi_pkg::TABLE_DEPTH)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[vdi_pkg::IDX_W-1:0]),
		.wr_data (key_q),
		.rd_en   (rd_en),
		.rd_addr (issue_q[vdi_pkg::IDX_W-1:0]),
		.rd_data (rd_data)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= vdi_pkg::ST_IDLE;
			cnt_q        <= '0;
			issue_q      <= '0;
			hit_q        <= 1'b0;
			cmp_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			cmp_valid_s1 <= rd_en;
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				vdi_pkg::ST_IDLE: begin
					if (accept) begin
						issue_q <= '0;
						hit_q   <= 1'b0;
						if (s_tuser) begin
							cnt_q <= '0;
						end
						// nothing to search: straight to the append
						if (s_tuser || (cnt_q == '0)) begin
							state_q <= vdi_pkg::ST_FINISH;
						end else begin
							state_q <= vdi_pkg::ST_SCAN;
						end
					end
				end
				vdi_pkg::ST_SCAN: begin
					if (rd_en) begin
						issue_q <= issue_nxt;
					end
					if (match) begin
						hit_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= vdi_pkg::ST_FINISH;
					end
				end
				vdi_pkg::ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (wr_en) begin
							cnt_q <= cnt_q + vdi_pkg::CNT_ONE;
						end
						state_q <= vdi_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= vdi_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= s_tdata;
		end
		cmp_idx_s1  <= issue_q[vdi_pkg::IDX_W-1:0];
		cmp_last_s1 <= (issue_nxt == cnt_q);
		if (match) begin
			hit_idx_q <= cmp_idx_s1;
		end
		if ((state_q == vdi_pkg::ST_FINISH) && out_free) begin
			if (hit_q) begin
				out_index_q <= vdi_pkg::out_index_t'(hit_idx_q);
				out_new_q   <= 1'b0;
				out_full_q  <= 1'b0;
			end else if (tbl_full) begin
				out_index_q <= '0;
				out_new_q   <= 1'b0;
				out_full_q  <= 1'b1;
			end else begin
				out_index_q <= vdi_pkg::out_index_t'(cnt_q);
				out_new_q   <= 1'b1;
				out_full_q  <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = vdi_pkg::OUT_TDATA_W'(out_index_q);
	always_comb begin
		m_tuser                            = '0;
		m_tuser[vdi_pkg::TUSER_IS_NEW]     = out_new_q;
		m_tuser[vdi_pkg::TUSER_TABLE_FULL] = out_full_q;
	end

endmodule

### rtl/core/vdi_checker.sv
`timescale 1ns / 1ps

module vdi_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [vdi_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input logic [vdi_pkg::OUT_TUSER_W-1:0]  m_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a request is never new and full at once
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[vdi_pkg::TUSER_IS_NEW] && m_tuser[vdi_pkg::TUSER_TABLE_FULL]))
		else $error("is_new and table_full both set");

	// full result carries index zero
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[vdi_pkg::TUSER_TABLE_FULL] |-> (m_tdata == '0))
		else $error("table_full with nonzero index");

	// one request in flight: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// first of mesh skips the scan: once the output register frees up,
	// the result is a new entry at index zero
	a_first_new: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=>
			(!m_tvalid || m_tready) [->1] ##1
			(m_tvalid && m_tuser[vdi_pkg::TUSER_IS_NEW] && (m_tdata == '0)))
		else $error("first-of-mesh request not answered as new entry zero");

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
